// File: sv/rru_pkg.sv
// Shared types, constants and helpers for the rectangle region union unit.
// No dependencies; every other file refers to this package by scoped names.
package rru_pkg;

  localparam int MAX_RECTS    = 32;
  localparam int WORK_DEPTH   = 16;
  localparam int COORD_BITS   = 16;
  localparam int RESULT_LIMIT = 32;

  localparam int RA_W = $clog2(MAX_RECTS);
  localparam int RC_W = $clog2(MAX_RECTS + 1);
  localparam int WA_W = $clog2(WORK_DEPTH);
  localparam int WC_W = $clog2(WORK_DEPTH + 1);
  localparam int NC_W = $clog2(RESULT_LIMIT + 1);

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [COORD_BITS:0]   ecrd_t;

  typedef struct packed {
    crd_t l;
    crd_t t;
    crd_t r;
    crd_t b;
  } box_t;

  // one extra bit so that edge +/- 1 never wraps
  typedef struct packed {
    ecrd_t l;
    ecrd_t t;
    ecrd_t r;
    ecrd_t b;
  } ebox_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLIP  = 2'd2,
    CMD_HIT   = 2'd3
  } cmd_e;

  // containment code: bit0 s.l>=p.l, bit1 s.t>=p.t, bit2 s.r<=p.r, bit3 s.b<=p.b
  typedef enum logic [3:0] {
    CODE_NONE = 4'h0,
    CODE_L    = 4'h1,
    CODE_T    = 4'h2,
    CODE_LT   = 4'h3,
    CODE_R    = 4'h4,
    CODE_LR   = 4'h5,
    CODE_TR   = 4'h6,
    CODE_LTR  = 4'h7,
    CODE_B    = 4'h8,
    CODE_LB   = 4'h9,
    CODE_TB   = 4'hA,
    CODE_LTB  = 4'hB,
    CODE_RB   = 4'hC,
    CODE_LRB  = 4'hD,
    CODE_TRB  = 4'hE,
    CODE_ALL  = 4'hF
  } code_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOADW,
    ST_RDS,
    ST_CMP,
    ST_SHS_RD,
    ST_SHS_WR,
    ST_SHW_RD,
    ST_SHW_WR,
    ST_APP_RD,
    ST_APP_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [15:0] in_left;
    logic signed [15:0] in_top;
    logic signed [15:0] in_right;
    logic signed [15:0] in_bottom;
  } req_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_top;
    logic signed [15:0] out_right;
    logic signed [15:0] out_bottom;
    logic               found;
    logic               status;
    logic [5:0]         stored_count;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [RA_W-1:0] s_raddr;
    logic            s_we;
    logic [RA_W-1:0] s_waddr;
    box_t            s_wdata;
    logic [WA_W-1:0] w_raddr;
    logic            w_we;
    logic [WA_W-1:0] w_waddr;
    box_t            w_wdata;
  } mem_ctl_t;

  typedef struct packed {
    logic  overlap;
    code_e code;
    ebox_t p;
    ebox_t q;
    logic  q_push;
    ebox_t s;
    logic  s_keep;
    logic  p_area;
    ebox_t clip;
    logic  clip_area;
    logic  hit;
  } cut_t;

  function automatic ebox_t ext(box_t a);
    ebox_t e;
    e.l = ecrd_t'(a.l);
    e.t = ecrd_t'(a.t);
    e.r = ecrd_t'(a.r);
    e.b = ecrd_t'(a.b);
    return e;
  endfunction

  function automatic box_t trunc(ebox_t e);
    box_t a;
    a.l = e.l[COORD_BITS-1:0];
    a.t = e.t[COORD_BITS-1:0];
    a.r = e.r[COORD_BITS-1:0];
    a.b = e.b[COORD_BITS-1:0];
    return a;
  endfunction

  function automatic logic area(ebox_t e);
    return (e.r >= e.l) && (e.b >= e.t);
  endfunction

endpackage

// File: sv/rru_cut.sv
// Shared compare/trim unit: containment code, piece cuts, clip and point test.
// Depends on rru_pkg.
module rru_cut (
  input  rru_pkg::box_t s_i,
  input  rru_pkg::box_t p_i,
  output rru_pkg::cut_t cut_o
);

  localparam rru_pkg::ecrd_t ONE = rru_pkg::ecrd_t'(1);

  rru_pkg::ebox_t s, p, np, nq, ns, c;
  logic           ovl;
  rru_pkg::code_e code;
  logic           split;

  assign s = rru_pkg::ext(s_i);
  assign p = rru_pkg::ext(p_i);

  always_comb begin
    c.l = (s.l > p.l) ? s.l : p.l;
    c.t = (s.t > p.t) ? s.t : p.t;
    c.r = (s.r < p.r) ? s.r : p.r;
    c.b = (s.b < p.b) ? s.b : p.b;
    ovl = (c.l <= c.r) && (c.t <= c.b);
    code = rru_pkg::code_e'({s.b <= p.b, s.r <= p.r, s.t >= p.t, s.l >= p.l});
    np = p;
    nq = p;
    ns = s;
    split = 1'b0;
    case (code)
      rru_pkg::CODE_NONE: ;
      rru_pkg::CODE_L:    np.r = s.l - ONE;
      rru_pkg::CODE_T:    np.b = s.t - ONE;
      rru_pkg::CODE_LT: begin
        np.r = s.l - ONE; np.t = s.t; nq.b = s.t - ONE; split = 1'b1;
      end
      rru_pkg::CODE_R:    np.l = s.r + ONE;
      rru_pkg::CODE_LR: begin
        np.l = s.r + ONE; nq.r = s.l - ONE; split = 1'b1;
      end
      rru_pkg::CODE_TR: begin
        np.l = s.r + ONE; np.t = s.t; nq.b = s.t - ONE; split = 1'b1;
      end
      rru_pkg::CODE_LTR:  ns.t = p.b + ONE;
      rru_pkg::CODE_B:    np.t = s.b + ONE;
      rru_pkg::CODE_LB: begin
        np.t = s.b + ONE; nq.r = s.l - ONE; nq.b = s.b; split = 1'b1;
      end
      rru_pkg::CODE_TB: begin
        np.t = s.b + ONE; nq.b = s.t - ONE; split = 1'b1;
      end
      rru_pkg::CODE_LTB:  ns.l = p.r + ONE;
      rru_pkg::CODE_RB: begin
        np.t = s.b + ONE; nq.l = s.r + ONE; nq.b = s.b; split = 1'b1;
      end
      rru_pkg::CODE_LRB:  ns.b = p.t - ONE;
      rru_pkg::CODE_TRB:  ns.r = p.l - ONE;
      default: ;
    endcase
  end

  always_comb begin
    cut_o.overlap   = ovl;
    cut_o.code      = code;
    cut_o.p         = np;
    cut_o.q         = nq;
    cut_o.q_push    = split && rru_pkg::area(nq);
    cut_o.s         = ns;
    cut_o.s_keep    = (code != rru_pkg::CODE_ALL) && rru_pkg::area(ns);
    cut_o.p_area    = rru_pkg::area(np);
    cut_o.clip      = c;
    cut_o.clip_area = ovl;
    cut_o.hit       = (p.l >= s.l) && (p.l <= s.r) && (p.t >= s.t) && (p.t <= s.b);
  end

endmodule

// File: sv/rru_mem.sv
// Rectangle table and work list memories, one write and one registered read each.
// Depends on rru_pkg.
module rru_mem (
  input  logic              clk_i,
  input  rru_pkg::mem_ctl_t ctl_i,
  output rru_pkg::box_t     s_rdata_o,
  output rru_pkg::box_t     w_rdata_o
);

  rru_pkg::box_t store_q [rru_pkg::MAX_RECTS];
  rru_pkg::box_t work_q  [rru_pkg::WORK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.s_we) begin
      store_q[ctl_i.s_waddr] <= ctl_i.s_wdata;
    end
    s_rdata_o <= store_q[ctl_i.s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.w_we) begin
      work_q[ctl_i.w_waddr] <= ctl_i.w_wdata;
    end
    w_rdata_o <= work_q[ctl_i.w_raddr];
  end

endmodule

// File: sv/rect_region_union_clip_unit.sv
// Region store top: clear and arealess add strobe their result the cycle after accept.
// Add: each work piece is loaded, compared with every stored rect and written back;
// emptied entries are shifted out, surviving pieces are appended, then the result.
// Clip/hit-test walk the stored rects in order (hit stops at the first hit).
// One request at a time: busy high while it runs; results are one-cycle strobes, no stall.
// rst_ni asynchronously empties the table; memory contents are not cleared.
module rect_region_union_clip_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rru_pkg::req_t req_i,
  output logic          busy,
  output logic          res_valid_o,
  output rru_pkg::res_t res_o
);

  localparam int RA_W = rru_pkg::RA_W;
  localparam int RC_W = rru_pkg::RC_W;
  localparam int WA_W = rru_pkg::WA_W;
  localparam int WC_W = rru_pkg::WC_W;
  localparam int NC_W = rru_pkg::NC_W;
  localparam int CW   = rru_pkg::COORD_BITS;

  rru_pkg::state_e   state_q, state_d;
  rru_pkg::cmd_e     cmd_q, cmd_d;
  rru_pkg::box_t     p_q, p_d, pbox_q, pbox_d, in_box;
  logic [WC_W-1:0]   w_q, w_d, wcnt_q, wcnt_d, kw_q, kw_d, kw_n;
  logic [RC_W-1:0]   j_q, j_d, rcnt_q, rcnt_d, ks_q, ks_d, ks_n;
  logic [NC_W-1:0]   n_q, n_d;
  logic              gone_q, gone_d, ovf_q, ovf_d, pend_q, pend_d;
  logic              res_valid_d;
  rru_pkg::res_t     res_d;
  rru_pkg::mem_ctl_t ctl;
  rru_pkg::box_t     s_rdata, w_rdata;
  rru_pkg::cut_t     cut;
  rru_pkg::box_t     zero_box;

  assign zero_box = '0;
  assign in_box.l = $signed(req_i.in_left[CW-1:0]);
  assign in_box.t = $signed(req_i.in_top[CW-1:0]);
  assign in_box.r = $signed(req_i.in_right[CW-1:0]);
  assign in_box.b = $signed(req_i.in_bottom[CW-1:0]);
  assign ks_n = ks_q + RC_W'(1);
  assign kw_n = kw_q + WC_W'(1);

  rru_mem u_mem (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .s_rdata_o(s_rdata),
    .w_rdata_o(w_rdata)
  );

  // one cut unit serves add, clip and hit-test
  rru_cut u_cut (
    .s_i  (s_rdata),
    .p_i  (p_q),
    .cut_o(cut)
  );

  function automatic rru_pkg::res_t mk_res(rru_pkg::box_t b, logic found, logic status,
                                           logic [RC_W-1:0] cnt, logic last);
    rru_pkg::res_t r;
    r.out_left     = 16'(b.l);
    r.out_top      = 16'(b.t);
    r.out_right    = 16'(b.r);
    r.out_bottom   = 16'(b.b);
    r.found        = found;
    r.status       = status;
    r.stored_count = 6'(cnt);
    r.last         = last;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rru_pkg::ST_IDLE;
      cmd_q       <= rru_pkg::CMD_CLEAR;
      w_q         <= '0;
      wcnt_q      <= '0;
      kw_q        <= '0;
      j_q         <= '0;
      rcnt_q      <= '0;
      ks_q        <= '0;
      n_q         <= '0;
      gone_q      <= 1'b0;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      w_q         <= w_d;
      wcnt_q      <= wcnt_d;
      kw_q        <= kw_d;
      j_q         <= j_d;
      rcnt_q      <= rcnt_d;
      ks_q        <= ks_d;
      n_q         <= n_d;
      gone_q      <= gone_d;
      ovf_q       <= ovf_d;
      pend_q      <= pend_d;
      res_valid_o <= res_valid_d;
    end
  end

  // payload only
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    pbox_q <= pbox_d;
    res_o  <= res_d;
  end

  assign busy = (state_q != rru_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    p_d         = p_q;
    pbox_d      = pbox_q;
    w_d         = w_q;
    wcnt_d      = wcnt_q;
    kw_d        = kw_q;
    j_d         = j_q;
    rcnt_d      = rcnt_q;
    ks_d        = ks_q;
    n_d         = n_q;
    gone_d      = gone_q;
    ovf_d       = ovf_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    res_d       = res_o;
    ctl         = '0;

    case (state_q)
      rru_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d = rru_pkg::cmd_e'(req_i.command);
          p_d   = in_box;
          case (rru_pkg::cmd_e'(req_i.command))
            rru_pkg::CMD_CLEAR: begin
              rcnt_d      = '0;
              wcnt_d      = '0;
              res_valid_d = 1'b1;
              res_d       = mk_res(zero_box, 1'b0, 1'b0, '0, 1'b1);
            end
            rru_pkg::CMD_ADD: begin
              if (!rru_pkg::area(rru_pkg::ext(in_box))) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(zero_box, 1'b0, 1'b0, rcnt_q, 1'b1);
              end else begin
                ctl.w_we    = 1'b1;
                ctl.w_waddr = '0;
                ctl.w_wdata = in_box;
                wcnt_d      = WC_W'(1);
                w_d         = '0;
                ovf_d       = 1'b0;
                state_d     = rru_pkg::ST_LOAD;
              end
            end
            default: begin
              j_d     = '0;
              n_d     = '0;
              pend_d  = 1'b0;
              state_d = rru_pkg::ST_SCAN_RD;
            end
          endcase
        end
      end

      // fetch the next work piece, or move on to appending
      rru_pkg::ST_LOAD: begin
        if (w_q == wcnt_q) begin
          w_d     = '0;
          state_d = rru_pkg::ST_APP_RD;
        end else begin
          ctl.w_raddr = w_q[WA_W-1:0];
          state_d     = rru_pkg::ST_LOADW;
        end
      end

      rru_pkg::ST_LOADW: begin
        p_d     = w_rdata;
        j_d     = '0;
        state_d = rru_pkg::ST_RDS;
      end

      rru_pkg::ST_RDS: begin
        if (j_q == rcnt_q) begin
          // piece survived every stored rect
          ctl.w_we    = 1'b1;
          ctl.w_waddr = w_q[WA_W-1:0];
          ctl.w_wdata = p_q;
          w_d         = w_q + WC_W'(1);
          state_d     = rru_pkg::ST_LOAD;
        end else begin
          ctl.s_raddr = j_q[RA_W-1:0];
          state_d     = rru_pkg::ST_CMP;
        end
      end

      rru_pkg::ST_CMP: begin
        if (!cut.overlap) begin
          j_d     = j_q + RC_W'(1);
          state_d = rru_pkg::ST_RDS;
        end else if (cut.code == rru_pkg::CODE_NONE) begin
          kw_d    = w_q;
          state_d = rru_pkg::ST_SHW_RD;
        end else begin
          p_d    = rru_pkg::trunc(cut.p);
          gone_d = !cut.p_area;
          if (cut.q_push) begin
            if (wcnt_q >= WC_W'(rru_pkg::WORK_DEPTH)) begin
              ovf_d = 1'b1;
            end else begin
              ctl.w_we    = 1'b1;
              ctl.w_waddr = wcnt_q[WA_W-1:0];
              ctl.w_wdata = rru_pkg::trunc(cut.q);
              wcnt_d      = wcnt_q + WC_W'(1);
            end
          end
          if (!cut.s_keep) begin
            ks_d    = j_q;
            state_d = rru_pkg::ST_SHS_RD;
          end else begin
            ctl.s_we    = 1'b1;
            ctl.s_waddr = j_q[RA_W-1:0];
            ctl.s_wdata = rru_pkg::trunc(cut.s);
            j_d         = j_q + RC_W'(1);
            if (!cut.p_area) begin
              kw_d    = w_q;
              state_d = rru_pkg::ST_SHW_RD;
            end else begin
              state_d = rru_pkg::ST_RDS;
            end
          end
        end
      end

      // close the gap left by a removed stored rect
      rru_pkg::ST_SHS_RD: begin
        if (ks_n >= rcnt_q) begin
          rcnt_d = rcnt_q - RC_W'(1);
          if (gone_q) begin
            kw_d    = w_q;
            state_d = rru_pkg::ST_SHW_RD;
          end else begin
            state_d = rru_pkg::ST_RDS;
          end
        end else begin
          ctl.s_raddr = ks_n[RA_W-1:0];
          state_d     = rru_pkg::ST_SHS_WR;
        end
      end

      rru_pkg::ST_SHS_WR: begin
        ctl.s_we    = 1'b1;
        ctl.s_waddr = ks_q[RA_W-1:0];
        ctl.s_wdata = s_rdata;
        ks_d        = ks_n;
        state_d     = rru_pkg::ST_SHS_RD;
      end

      // close the gap left by a consumed piece
      rru_pkg::ST_SHW_RD: begin
        if (kw_n >= wcnt_q) begin
          wcnt_d  = wcnt_q - WC_W'(1);
          state_d = rru_pkg::ST_LOAD;
        end else begin
          ctl.w_raddr = kw_n[WA_W-1:0];
          state_d     = rru_pkg::ST_SHW_WR;
        end
      end

      rru_pkg::ST_SHW_WR: begin
        ctl.w_we    = 1'b1;
        ctl.w_waddr = kw_q[WA_W-1:0];
        ctl.w_wdata = w_rdata;
        kw_d        = kw_n;
        state_d     = rru_pkg::ST_SHW_RD;
      end

      rru_pkg::ST_APP_RD: begin
        if (w_q == wcnt_q) begin
          res_valid_d = 1'b1;
          res_d       = mk_res(zero_box, 1'b0, ovf_q, rcnt_q, 1'b1);
          state_d     = rru_pkg::ST_IDLE;
        end else begin
          ctl.w_raddr = w_q[WA_W-1:0];
          state_d     = rru_pkg::ST_APP_WR;
        end
      end

      rru_pkg::ST_APP_WR: begin
        if (rcnt_q >= RC_W'(rru_pkg::MAX_RECTS)) begin
          ovf_d = 1'b1;
        end else begin
          ctl.s_we    = 1'b1;
          ctl.s_waddr = rcnt_q[RA_W-1:0];
          ctl.s_wdata = w_rdata;
          rcnt_d      = rcnt_q + RC_W'(1);
        end
        w_d     = w_q + WC_W'(1);
        state_d = rru_pkg::ST_APP_RD;
      end

      // clip and hit-test walk the table in order
      rru_pkg::ST_SCAN_RD: begin
        if ((j_q == rcnt_q) ||
            ((cmd_q == rru_pkg::CMD_CLIP) && (n_q == NC_W'(rru_pkg::RESULT_LIMIT)))) begin
          res_valid_d = 1'b1;
          if (pend_q) begin
            res_d = mk_res(pbox_q, 1'b1, 1'b0, rcnt_q, 1'b1);
          end else begin
            res_d = mk_res(zero_box, 1'b0, 1'b0, rcnt_q, 1'b1);
          end
          state_d = rru_pkg::ST_IDLE;
        end else begin
          ctl.s_raddr = j_q[RA_W-1:0];
          state_d     = rru_pkg::ST_SCAN_CHK;
        end
      end

      rru_pkg::ST_SCAN_CHK: begin
        j_d     = j_q + RC_W'(1);
        state_d = rru_pkg::ST_SCAN_RD;
        if (cmd_q == rru_pkg::CMD_HIT) begin
          if (cut.hit) begin
            res_valid_d = 1'b1;
            res_d       = mk_res(zero_box, 1'b1, 1'b0, rcnt_q, 1'b1);
            state_d     = rru_pkg::ST_IDLE;
          end
        end else if (cut.clip_area) begin
          // hold one back so the final one can carry last
          if (pend_q) begin
            res_valid_d = 1'b1;
            res_d       = mk_res(pbox_q, 1'b1, 1'b0, rcnt_q, 1'b0);
          end
          pbox_d = rru_pkg::trunc(cut.clip);
          pend_d = 1'b1;
          n_d    = n_q + NC_W'(1);
        end
      end

      default: state_d = rru_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("final result while still busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final result after request finished");

  a_rcnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= RC_W'(rru_pkg::MAX_RECTS))
    else $error("table count beyond capacity");

  a_wcnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= WC_W'(rru_pkg::WORK_DEPTH))
    else $error("work list count beyond capacity");

  a_status_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status |-> cmd_q == rru_pkg::CMD_ADD)
    else $error("overflow status outside add");
`endif

endmodule
